@@ rtl/ws2812_pkg.sv @@
`timescale 1ns / 1ps

package ws2812_pkg;

    // field and register widths
    localparam int PIX_W      = 24;
    localparam int TICK_W     = 15;
    localparam int COUNT_W    = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // first bit sent of a pixel (green msb)
    localparam logic [4:0] BIT_START = 5'd23;

    // register reset values
    localparam logic [COUNT_W-1:0] LED_COUNT_RST = 9'd1;
    localparam logic [TICK_W-1:0]  ZERO_HIGH_RST = 15'd3;
    localparam logic [TICK_W-1:0]  ZERO_LOW_RST  = 15'd9;
    localparam logic [TICK_W-1:0]  ONE_HIGH_RST  = 15'd8;
    localparam logic [TICK_W-1:0]  ONE_LOW_RST   = 15'd4;

    // item commands
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LED_COUNT = 3'd0,
        REG_ZERO_HIGH = 3'd1,
        REG_ZERO_LOW  = 3'd2,
        REG_ONE_HIGH  = 3'd3,
        REG_ONE_LOW   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        cmd_t             op;
        logic             in_range;
        logic [7:0]       index;
        logic [PIX_W-1:0] grb;
    } op_item_t;

endpackage

@@ rtl/ws2812_pixel_string_driver.sv @@
`timescale 1ns / 1ps

// WS2812 LED string driver. Items on the s_ channel are ticks, pixel writes or
// clear-all commands; each item gives exactly one result on the m_ channel with
// the line level after that item, a busy flag and a frame-done pulse. The block
// takes one item every clock cycle, sustained, while the receiver keeps m_ready high.
// Each item passes through the two-entry queue between the classifier and the
// serializer, then the result register, before its result is offered. The pixel
// store is a single-port-write RAM of MAX_PIXELS words with a registered read that
// prefetches the next pixel of the frame; per-entry valid flags make reset and
// clear-all take effect at once, so no clearing pass is needed after reset.
// Phase lengths and pixel count are written through the cfg_ port; the user must
// write them only while the block is idle; the block does not enforce this;
// cfg_ready is always high.
module ws2812_pixel_string_driver #(
    parameter int MAX_PIXELS = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ws2812_pkg::in_item_t               s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ws2812_pkg::out_item_t              m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ws2812_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ws2812_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                 q_push, q_pop, q_full, q_empty;
    ws2812_pkg::op_item_t q_in_item, q_out_item;

    assign cfg_ready = 1'b1;

    // classifier
    ws2812_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_in_item)
    );

    // decoupling queue
    ws2812_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .pop_item  (q_out_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    // serializer, pixel store and result register
    ws2812_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_item    (q_out_item),
        .q_pop     (q_pop),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ rtl/ws2812_ram.sv @@
`timescale 1ns / 1ps

module ws2812_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ws2812_fifo.sv @@
`timescale 1ns / 1ps

module ws2812_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ws2812_pkg::op_item_t push_item,
    input  logic                pop,
    output ws2812_pkg::op_item_t pop_item,
    output logic                full,
    output logic                empty
);

    ws2812_pkg::op_item_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item = mem_reg[rd_ptr_reg];
    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);

    // occupancy never passes two entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");

    // no pop from an empty queue, no push into a full one
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty) && !(push && full && !pop))
        else $error("queue overrun or underrun");

endmodule

@@ rtl/ws2812_front.sv @@
`timescale 1ns / 1ps

module ws2812_front #(
    parameter int MAX_PIXELS = 256
) (
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ws2812_pkg::in_item_t s_data,
    input  logic                 q_full,
    output logic                 q_push,
    output ws2812_pkg::op_item_t q_item
);

    // take an item whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // classify the item and pack the pixel word
    always_comb begin
        q_item.index    = s_data.pixel_index;
        q_item.grb      = {s_data.green, s_data.red, s_data.blue};
        q_item.in_range = (32'(s_data.pixel_index) < MAX_PIXELS);
        unique case (ws2812_pkg::cmd_t'(s_data.cmd))
            ws2812_pkg::CMD_TICK:  q_item.op = ws2812_pkg::CMD_TICK;
            ws2812_pkg::CMD_SET:   q_item.op = ws2812_pkg::CMD_SET;
            ws2812_pkg::CMD_CLEAR: q_item.op = ws2812_pkg::CMD_CLEAR;
            default:               q_item.op = ws2812_pkg::CMD_NONE;
        endcase
    end

endmodule

@@ rtl/ws2812_back.sv @@
`timescale 1ns / 1ps

module ws2812_back #(
    parameter int MAX_PIXELS = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_empty,
    input  ws2812_pkg::op_item_t                q_item,
    output logic                                q_pop,
    input  logic                                cfg_wr,
    input  logic [ws2812_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ws2812_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ws2812_pkg::out_item_t               m_data
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW = ((AW > ws2812_pkg::COUNT_W) ? AW : ws2812_pkg::COUNT_W) + 1;
    localparam int PW = ws2812_pkg::PIX_W;
    localparam int TW = ws2812_pkg::TICK_W;

    // configuration
    logic [ws2812_pkg::COUNT_W-1:0] led_count_reg;
    logic [TW-1:0] zero_high_reg, zero_low_reg, one_high_reg, one_low_reg;

    // serializer state
    logic [AW-1:0] pc_reg, pc_next;
    logic [4:0]    bit_reg, bit_next;
    logic [TW-1:0] phase_reg, phase_next;
    logic          high_reg, high_next;
    logic          sending_reg, sending_next;
    logic          pending_reg, pending_next;
    logic          cur_bit_reg, cur_bit_next;
    logic [PW-1:0] cur_word_reg, cur_word_next;
    logic [PW-1:0] word0_reg, word0_next;

    // store bookkeeping
    logic [MAX_PIXELS-1:0] valid_reg;
    logic          wr_en;
    logic          clr_all;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [PW-1:0] ram_q;
    logic          pf_valid_reg, pf_hit_reg, pf_clr_reg;
    logic [PW-1:0] pf_data_reg;
    logic [PW-1:0] pf_word;

    // helpers
    logic [CW-1:0] led_ext, max_ext, eff_count, pc_inc, pc_next_inc;
    logic [TW-1:0] len_sel, len_eff, phase_inc;
    logic [4:0]    bit_dec;
    logic          done;

    // output register
    logic                  m_valid_reg;
    ws2812_pkg::out_item_t m_data_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_count_reg <= ws2812_pkg::LED_COUNT_RST;
            zero_high_reg <= ws2812_pkg::ZERO_HIGH_RST;
            zero_low_reg  <= ws2812_pkg::ZERO_LOW_RST;
            one_high_reg  <= ws2812_pkg::ONE_HIGH_RST;
            one_low_reg   <= ws2812_pkg::ONE_LOW_RST;
        end else if (cfg_wr) begin
            unique case (ws2812_pkg::cfg_reg_t'(cfg_index))
                ws2812_pkg::REG_LED_COUNT:
                    led_count_reg <= cfg_data[ws2812_pkg::COUNT_W-1:0];
                ws2812_pkg::REG_ZERO_HIGH: zero_high_reg <= cfg_data;
                ws2812_pkg::REG_ZERO_LOW:  zero_low_reg  <= cfg_data;
                ws2812_pkg::REG_ONE_HIGH:  one_high_reg  <= cfg_data;
                ws2812_pkg::REG_ONE_LOW:   one_low_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // frame length clamped to 1..MAX_PIXELS
    assign led_ext   = CW'(led_count_reg);
    assign max_ext   = CW'(MAX_PIXELS);
    assign eff_count = (led_ext == '0) ? CW'(1) : ((led_ext > max_ext) ? max_ext : led_ext);

    // current phase length, zero counts as one
    assign len_sel   = high_reg ? (cur_bit_reg ? one_high_reg : zero_high_reg)
                                : (cur_bit_reg ? one_low_reg : zero_low_reg);
    assign len_eff   = (len_sel == '0) ? TW'(1) : len_sel;
    assign phase_inc = phase_reg + TW'(1);
    assign pc_inc    = CW'(pc_reg) + CW'(1);
    assign bit_dec   = bit_reg - 5'd1;

    // take an item when the output register is free or draining
    assign q_pop   = !q_empty && (!m_valid_reg || m_ready);
    assign wr_addr = AW'(q_item.index);

    // next pixel word: ram data patched with the last cycle's write or clear
    assign pf_word = pf_clr_reg ? '0 :
                     (pf_hit_reg ? pf_data_reg : (pf_valid_reg ? ram_q : '0));

    // serializer and store update
    always_comb begin
        pc_next       = pc_reg;
        bit_next      = bit_reg;
        phase_next    = phase_reg;
        high_next     = high_reg;
        sending_next  = sending_reg;
        pending_next  = pending_reg;
        cur_bit_next  = cur_bit_reg;
        cur_word_next = cur_word_reg;
        word0_next    = word0_reg;
        wr_en         = 1'b0;
        clr_all       = 1'b0;
        done          = 1'b0;
        if (q_pop) begin
            unique case (q_item.op)
                ws2812_pkg::CMD_TICK: begin
                    if (sending_reg) begin
                        if (phase_inc < len_eff) begin
                            phase_next = phase_inc;
                        end else begin
                            phase_next = '0;
                            if (high_reg) begin
                                high_next = 1'b0;
                            end else if (bit_reg != 5'd0) begin
                                bit_next     = bit_dec;
                                cur_bit_next = cur_word_reg[bit_dec];
                                high_next    = 1'b1;
                            end else if (pc_inc < eff_count) begin
                                pc_next       = AW'(pc_inc);
                                bit_next      = ws2812_pkg::BIT_START;
                                cur_word_next = pf_word;
                                cur_bit_next  = pf_word[ws2812_pkg::BIT_START];
                                high_next     = 1'b1;
                            end else begin
                                done         = 1'b1;
                                sending_next = 1'b0;
                                high_next    = 1'b0;
                                pc_next      = '0;
                                bit_next     = 5'd0;
                            end
                        end
                    end
                end
                ws2812_pkg::CMD_SET: begin
                    if (q_item.in_range) begin
                        wr_en = 1'b1;
                        if (wr_addr == '0) begin
                            word0_next = q_item.grb;
                        end
                        if (wr_addr == pc_reg) begin
                            cur_word_next = q_item.grb;
                        end
                    end
                end
                ws2812_pkg::CMD_CLEAR: begin
                    clr_all       = 1'b1;
                    word0_next    = '0;
                    cur_word_next = '0;
                end
                default: ;
            endcase

            // frame request from a write, or the queued frame after an end
            if ((q_item.op == ws2812_pkg::CMD_SET || q_item.op == ws2812_pkg::CMD_CLEAR)
                    && sending_reg) begin
                pending_next = 1'b1;
            end else if ((q_item.op == ws2812_pkg::CMD_SET ||
                          q_item.op == ws2812_pkg::CMD_CLEAR) ||
                         (done && pending_reg)) begin
                pending_next  = 1'b0;
                sending_next  = 1'b1;
                pc_next       = '0;
                bit_next      = ws2812_pkg::BIT_START;
                cur_word_next = word0_next;
                cur_bit_next  = word0_next[ws2812_pkg::BIT_START];
                high_next     = 1'b1;
                phase_next    = '0;
            end
        end
    end

    // prefetch address follows the pixel after the next current one
    assign pc_next_inc = CW'(pc_next) + CW'(1);
    assign rd_addr     = (pc_next_inc < max_ext) ? AW'(pc_next_inc) : '0;

    ws2812_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (q_item.grb),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= '0;
            bit_reg      <= 5'd0;
            phase_reg    <= '0;
            high_reg     <= 1'b0;
            sending_reg  <= 1'b0;
            pending_reg  <= 1'b0;
            cur_bit_reg  <= 1'b0;
            cur_word_reg <= '0;
            word0_reg    <= '0;
            valid_reg    <= '0;
            pf_valid_reg <= 1'b0;
            pf_hit_reg   <= 1'b0;
            pf_clr_reg   <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            bit_reg      <= bit_next;
            phase_reg    <= phase_next;
            high_reg     <= high_next;
            sending_reg  <= sending_next;
            pending_reg  <= pending_next;
            cur_bit_reg  <= cur_bit_next;
            cur_word_reg <= cur_word_next;
            word0_reg    <= word0_next;
            if (clr_all) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            pf_valid_reg <= valid_reg[rd_addr];
            pf_hit_reg   <= wr_en && (wr_addr == rd_addr);
            pf_clr_reg   <= clr_all;
        end
    end

    // bypass data for the prefetch
    always_ff @(posedge aclk) begin
        pf_data_reg <= q_item.grb;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_data_reg.line_level <= sending_next && high_next;
            m_data_reg.busy_res   <= sending_next || pending_next;
            m_data_reg.frame_done <= done;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a queued frame only exists behind a running one
    assert property (@(posedge aclk) disable iff (!aresetn)
        sending_reg || !pending_reg)
        else $error("frame queued while idle");

    // bit and pixel position stay inside the frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        sending_reg |-> (bit_reg <= ws2812_pkg::BIT_START) && (CW'(pc_reg) < max_ext))
        else $error("serializer position out of range");

    // a write while idle starts a frame with a fresh high phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !sending_reg &&
         (q_item.op == ws2812_pkg::CMD_SET || q_item.op == ws2812_pkg::CMD_CLEAR))
        |=> (sending_reg && high_reg && phase_reg == '0 && pc_reg == '0))
        else $error("frame did not start");

endmodule

@@ verif/ws2812_pixel_string_driver_tb.sv @@
`timescale 1ns / 1ps

module ws2812_pixel_string_driver_tb;

    localparam int MAX_PIX        = 256;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // block ports
    logic                              s_valid   = 1'b0;
    logic                              s_ready;
    ws2812_pkg::in_item_t              s_data    = '0;
    logic                              m_valid;
    logic                              m_ready   = 1'b0;
    ws2812_pkg::out_item_t             m_data;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [ws2812_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ws2812_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    ws2812_pixel_string_driver #(
        .MAX_PIXELS(MAX_PIX)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // traffic shaping
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_left    = 0;
    int err_count    = 0;

    // expected line states, oldest first
    ws2812_pkg::out_item_t line_state_q[$];

    // serializer shadow: registers
    logic [8:0]                    cnt_reg;
    logic [ws2812_pkg::TICK_W-1:0] zh_reg;
    logic [ws2812_pkg::TICK_W-1:0] zl_reg;
    logic [ws2812_pkg::TICK_W-1:0] oh_reg;
    logic [ws2812_pkg::TICK_W-1:0] ol_reg;

    // serializer shadow: store and frame state
    logic [ws2812_pkg::PIX_W-1:0]  grb_mem [MAX_PIX];
    int                            cur_pixel;
    logic [4:0]                    bits_left;
    logic [ws2812_pkg::TICK_W-1:0] slot_count;
    bit                            in_high;
    bit                            framing;
    bit                            frame_queued;
    bit                            sent_bit;

    // latch the next bit and open its high phase
    function automatic void start_bit();
        sent_bit   = grb_mem[cur_pixel][bits_left];
        in_high    = 1'b1;
        slot_count = '0;
    endfunction

    function automatic void begin_frame();
        framing   = 1'b1;
        cur_pixel = 0;
        bits_left = ws2812_pkg::BIT_START;
        start_bit();
    endfunction

    // set and clear start a frame, or queue one behind the running frame
    function automatic void ask_frame();
        if (framing) frame_queued = 1'b1;
        else begin_frame();
    endfunction

    // one tick of the waveform; returns 1 when the frame ends
    function automatic bit step_tick();
        logic [ws2812_pkg::TICK_W-1:0] len;
        int                            n;
        if (in_high) len = sent_bit ? oh_reg : zh_reg;
        else len = sent_bit ? ol_reg : zl_reg;
        if (len == '0) len = 15'd1;
        slot_count = slot_count + 1'b1;
        if (slot_count < len) return 1'b0;
        slot_count = '0;
        if (in_high) begin
            in_high = 1'b0;
            return 1'b0;
        end
        if (bits_left != 0) begin
            bits_left = bits_left - 1'b1;
            start_bit();
            return 1'b0;
        end
        n = (cnt_reg == 0) ? 1 : ((cnt_reg > MAX_PIX) ? MAX_PIX : int'(cnt_reg));
        if (cur_pixel + 1 < n) begin
            cur_pixel = cur_pixel + 1;
            bits_left = ws2812_pkg::BIT_START;
            start_bit();
            return 1'b0;
        end
        framing   = 1'b0;
        in_high   = 1'b0;
        cur_pixel = 0;
        bits_left = '0;
        return 1'b1;
    endfunction

    // expected line state after one item
    function automatic ws2812_pkg::out_item_t predict_line_state(ws2812_pkg::in_item_t it);
        ws2812_pkg::out_item_t res;
        bit                    done;
        done = 1'b0;
        case (ws2812_pkg::cmd_t'(it.cmd))
            ws2812_pkg::CMD_TICK: begin
                if (framing) begin
                    done = step_tick();
                    if (done && frame_queued) begin
                        frame_queued = 1'b0;
                        begin_frame();
                    end
                end
            end
            ws2812_pkg::CMD_SET: begin
                grb_mem[it.pixel_index] = {it.green, it.red, it.blue};
                ask_frame();
            end
            ws2812_pkg::CMD_CLEAR: begin
                foreach (grb_mem[i]) grb_mem[i] = '0;
                ask_frame();
            end
            default: ;
        endcase
        res.line_level = framing && in_high;
        res.busy_res   = framing || frame_queued;
        res.frame_done = done;
        return res;
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("mismatch: %s", msg);
    endtask

    // random item, indexes biased toward the pixels that get sent
    function automatic ws2812_pkg::in_item_t pick_item();
        ws2812_pkg::in_item_t it;
        int                   r;
        r = $urandom_range(99);
        if (r < 78) it.cmd = ws2812_pkg::CMD_TICK;
        else if (r < 90) it.cmd = ws2812_pkg::CMD_SET;
        else if (r < 95) it.cmd = ws2812_pkg::CMD_CLEAR;
        else it.cmd = ws2812_pkg::CMD_NONE;
        it.pixel_index = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
        it.red   = 8'($urandom);
        it.green = 8'($urandom);
        it.blue  = 8'($urandom);
        return it;
    endfunction

    function automatic ws2812_pkg::in_item_t with_cmd(ws2812_pkg::cmd_t c);
        ws2812_pkg::in_item_t it;
        it     = pick_item();
        it.cmd = c;
        return it;
    endfunction

    function automatic ws2812_pkg::in_item_t pixel_item(logic [7:0] idx, logic [7:0] g,
                                                        logic [7:0] r, logic [7:0] b);
        ws2812_pkg::in_item_t it;
        it.cmd         = ws2812_pkg::CMD_SET;
        it.pixel_index = idx;
        it.red         = r;
        it.green       = g;
        it.blue        = b;
        return it;
    endfunction

    // offer one item, with random sender gaps, and record its expectation
    task automatic send_item(input ws2812_pkg::in_item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        line_state_q.push_back(predict_line_state(it));
    endtask

    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++) send_item(with_cmd(ws2812_pkg::CMD_TICK));
    endtask

    // tick until no frame runs or waits, then let every result drain
    task automatic finish_frames();
        while (framing || frame_queued) send_item(with_cmd(ws2812_pkg::CMD_TICK));
        s_valid <= 1'b0;
        while (line_state_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // write all five registers once the block is idle
    task automatic load_regs(input logic [ws2812_pkg::CFG_DATA_W-1:0] count, zh, zl, oh, ol);
        logic [ws2812_pkg::CFG_DATA_W-1:0] vals [5];
        ws2812_pkg::cfg_reg_t              ri;
        finish_frames();
        vals = '{count, zh, zl, oh, ol};
        for (int i = 0; i < 5; i++) begin
            ri = ws2812_pkg::cfg_reg_t'(i);
            cfg_valid <= 1'b1;
            cfg_index <= ri;
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            case (ri)
                ws2812_pkg::REG_LED_COUNT: cnt_reg = vals[i][8:0];
                ws2812_pkg::REG_ZERO_HIGH: zh_reg  = vals[i];
                ws2812_pkg::REG_ZERO_LOW:  zl_reg  = vals[i];
                ws2812_pkg::REG_ONE_HIGH:  oh_reg  = vals[i];
                ws2812_pkg::REG_ONE_LOW:   ol_reg  = vals[i];
                default: ;
            endcase
            @(posedge aclk);
        end
    endtask

    // result checking and receiver stalls
    always @(posedge aclk) begin : result_check
        ws2812_pkg::out_item_t want;
        if (m_valid && m_ready) begin
            if (line_state_q.size() == 0) begin
                flag_error($sformatf("result %b with no item pending", m_data));
            end else begin
                want = line_state_q.pop_front();
                if (m_data.line_level !== want.line_level)
                    flag_error($sformatf("line_level expected %b actual %b",
                                         want.line_level, m_data.line_level));
                if (m_data.busy_res !== want.busy_res)
                    flag_error($sformatf("busy_res expected %b actual %b",
                                         want.busy_res, m_data.busy_res));
                if (m_data.frame_done !== want.frame_done)
                    flag_error($sformatf("frame_done expected %b actual %b",
                                         want.frame_done, m_data.frame_done));
            end
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog on cycles with no handshake at all
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    // reset register values, a frame from a fresh store
    task automatic test_reset_defaults();
        send_item(with_cmd(ws2812_pkg::CMD_NONE));
        send_item(with_cmd(ws2812_pkg::CMD_TICK));
        send_item(pixel_item(8'd0, 8'h0F, 8'hF0, 8'h3C));
        send_ticks(5);
        send_item(with_cmd(ws2812_pkg::CMD_NONE));
        finish_frames();
    endtask

    // queued frames, writes landing mid-frame, field extremes
    task automatic test_directed_items();
        load_regs(15'd2, 15'd1, 15'd2, 15'd2, 15'd1);
        send_item(pixel_item(8'd0, 8'hFF, 8'hFF, 8'hFF));
        send_item(pixel_item(8'd1, 8'h00, 8'hA5, 8'h5A));
        send_item(with_cmd(ws2812_pkg::CMD_NONE));
        send_ticks(10);
        // clear while sending: only bits not yet begun go out as zero
        send_item(with_cmd(ws2812_pkg::CMD_CLEAR));
        // last entry is stored but lies beyond the frame
        send_item(pixel_item(8'd255, 8'h12, 8'h34, 8'h56));
        send_ticks(4);
        // second pixel not begun yet, so the new value is sent
        send_item(pixel_item(8'd1, 8'h80, 8'h01, 8'hFF));
        finish_frames();
    endtask

    // zero count and zero phase lengths act as one
    task automatic test_config_extremes();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        load_regs(15'd0, 15'd0, 15'd0, 15'd0, 15'd0);
        send_item(pixel_item(8'd0, 8'hC3, 8'h3C, 8'h99));
        send_item(pixel_item(8'd0, 8'h01, 8'h80, 8'h7E));
        send_item(pixel_item(8'd255, 8'hFF, 8'hFF, 8'hFF));
        finish_frames();
    endtask

    // random items on a short string with short random phases
    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
        load_regs(15'($urandom_range(2, 1)), 15'($urandom_range(2)), 15'($urandom_range(2)),
                  15'($urandom_range(2)), 15'($urandom_range(2)));
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int i = 0; i < n_items; i++) send_item(pick_item());
        finish_frames();
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_back_pressure();
        load_regs(15'd2, 15'd1, 15'd1, 15'd2, 15'd1);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_left    = HOLD_CYCLES;
        for (int i = 0; i < 50; i++) send_item(pick_item());
        finish_frames();
    endtask

    initial begin
        int tx_modes [4];
        int rx_modes [4];
        tx_modes = '{0, 68, 0, 38};
        rx_modes = '{0, 0, 68, 38};

        // shadow state matches the block after reset
        foreach (grb_mem[i]) grb_mem[i] = '0;
        cnt_reg      = ws2812_pkg::LED_COUNT_RST;
        zh_reg       = ws2812_pkg::ZERO_HIGH_RST;
        zl_reg       = ws2812_pkg::ZERO_LOW_RST;
        oh_reg       = ws2812_pkg::ONE_HIGH_RST;
        ol_reg       = ws2812_pkg::ONE_LOW_RST;
        cur_pixel    = 0;
        bits_left    = '0;
        slot_count   = '0;
        in_high      = 1'b0;
        framing      = 1'b0;
        frame_queued = 1'b0;
        sent_bit     = 1'b0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_directed_items();
        test_config_extremes();
        for (int p = 0; p < 4; p++) test_random_traffic(tx_modes[p], rx_modes[p], 75);
        test_back_pressure();
        finish_frames();

        if (err_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
